FILE: design/sle_pkg.sv
// Shared types, codes and defaults for the sorted list engine.
package sle_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned CapacityDef = 16;
  localparam int unsigned KeyWidthDef = 32;

  // Fixed widths of the transfer fields.
  localparam int unsigned KeyBits   = 32;
  localparam int unsigned PosBits   = 4;
  localparam int unsigned CountBits = 5;
  localparam int unsigned StatBits  = 2;
  localparam int unsigned PosSpan   = 2 ** PosBits;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_MEMBER = 2'd3
  } op_e;

  // Status codes returned with every result.
  typedef enum logic [StatBits-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_RANGE     = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE
  } state_e;

  // One input item.
  typedef struct packed {
    op_e                operation;
    logic [KeyBits-1:0] key;
    logic [PosBits-1:0] position;
  } in_item_t;

  // One result item.
  typedef struct packed {
    status_e              status;
    logic [KeyBits-1:0]   read_value;
    logic                 found;
    logic [KeyBits-1:0]   head_value;
    logic [CountBits-1:0] entry_count;
    logic                 is_empty;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic compare;
    logic commit;
  } dp_cmd_t;

endpackage

FILE: design/sle_ctrl.sv
// Controller state machine that sequences load, compare and commit.
module sle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sle_pkg::dp_cmd_t  cmd_o
);

  sle_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            commit_ok;

  // The result can be committed once the output register is free or is being drained.
  assign commit_ok = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sle_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sle_pkg::ST_COMPARE;
        end
      end
      sle_pkg::ST_COMPARE: begin
        state_d = sle_pkg::ST_UPDATE;
      end
      sle_pkg::ST_UPDATE: begin
        if (commit_ok) begin
          state_d = in_valid_i ? sle_pkg::ST_COMPARE : sle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sle_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      sle_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      sle_pkg::ST_COMPARE: begin
        cmd_o.compare = 1'b1;
      end
      sle_pkg::ST_UPDATE: begin
        in_ready_o   = commit_ok;
        cmd_o.commit = commit_ok;
        cmd_o.load   = commit_ok && in_valid_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // A commit fills the output register; a transfer on the result side empties it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sle_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: design/sle_datapath.sv
// Datapath: a row of key cells with per-cell compare and parallel shift.
module sle_datapath #(
  parameter int unsigned CAPACITY  = sle_pkg::CapacityDef,
  parameter int unsigned KEY_WIDTH = sle_pkg::KeyWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sle_pkg::dp_cmd_t   cmd_i,
  input  sle_pkg::in_item_t  in_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_data_i,
  output sle_pkg::out_item_t out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Stored keys and the fill count; entries at or above the count are never read.
  logic [KEY_WIDTH-1:0] entries_q [CAPACITY];
  logic [KEY_WIDTH-1:0] entries_d [CAPACITY];
  logic [CntW-1:0]      count_q, count_d;
  logic                 signed_q;

  // Latched item.
  sle_pkg::op_e                  op_q;
  logic [KEY_WIDTH-1:0]          key_q;
  logic [sle_pkg::PosBits-1:0]   pos_q;

  // Registered compare results.
  logic [CAPACITY-1:0]  gt_q, gt_d;
  logic [CAPACITY-1:0]  eq_q, eq_d;
  logic [KEY_WIDTH-1:0] rd_q, rd_d;

  logic [63:0]          key_wide;
  logic [KEY_WIDTH-1:0] sign_flip;
  logic [KEY_WIDTH-1:0] key_ord;
  logic [KEY_WIDTH-1:0] ent_ord [CAPACITY];
  logic [CAPACITY-1:0]  live;
  logic [CAPACITY-1:0]  place;
  logic [CAPACITY-1:0]  pull;
  logic                 full;
  logic                 found_any;
  logic                 pos_ok;
  logic [63:0]          rd_wide;
  logic [63:0]          head_wide;

  sle_pkg::out_item_t   out_q, out_d;

  // Key widened to 64 bits; it is reduced to the stored width when latched.
  assign key_wide = 64'(in_i.key);

  // Signed order is unsigned order with the top bit inverted.
  assign sign_flip = {signed_q, {(KEY_WIDTH-1){1'b0}}};
  assign key_ord   = key_q ^ sign_flip;

  // Cells below the fill count hold keys.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i]    = CntW'(i) < count_q;
      ent_ord[i] = entries_q[i] ^ sign_flip;
    end
  end

  // Compare stage: every cell against the key, and the entry at the read position.
  always_comb begin
    rd_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      gt_d[i] = live[i] && (ent_ord[i] >  key_ord);
      eq_d[i] = live[i] && (entries_q[i] == key_q);
      if (i < sle_pkg::PosSpan && pos_q == sle_pkg::PosBits'(i)) begin
        rd_d = entries_q[i];
      end
    end
  end

  // Insert span: every cell from the first greater key or the first free cell onward.
  // Remove span: every cell from the first equal key onward. Both hold even when the
  // stored keys were ordered under the other setting of the order register.
  always_comb begin
    place[0] = gt_q[0] | ~live[0];
    pull[0]  = eq_q[0];
    for (int i = 1; i < CAPACITY; i++) begin
      place[i] = place[i-1] | gt_q[i] | ~live[i];
      pull[i]  = pull[i-1] | eq_q[i];
    end
  end

  assign full      = count_q == CntW'(CAPACITY);
  assign found_any = |eq_q;
  assign pos_ok    = 32'(pos_q) < 32'(count_q);
  assign rd_wide   = 64'(rd_q);

  // Update stage: new cell contents, count and result.
  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    out_d     = '0;
    out_d.status = sle_pkg::STATUS_OK;
    unique case (op_q)
      sle_pkg::OP_INSERT: begin
        if (full) begin
          out_d.status = sle_pkg::STATUS_FULL;
        end else begin
          if (place[0]) begin
            entries_d[0] = key_q;
          end
          for (int i = 1; i < CAPACITY; i++) begin
            if (place[i-1]) begin
              entries_d[i] = entries_q[i-1];
            end else if (place[i]) begin
              entries_d[i] = key_q;
            end
          end
          count_d = count_q + CntW'(1);
        end
      end
      sle_pkg::OP_REMOVE: begin
        if (!found_any) begin
          out_d.status = sle_pkg::STATUS_NOT_FOUND;
        end else begin
          // Every cell from the first equal key onward pulls from the cell above.
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (pull[i]) begin
              entries_d[i] = entries_q[i+1];
            end
          end
          count_d = count_q - CntW'(1);
        end
      end
      sle_pkg::OP_READ: begin
        if (pos_ok) begin
          out_d.read_value = rd_wide[sle_pkg::KeyBits-1:0];
        end else begin
          out_d.status = sle_pkg::STATUS_RANGE;
        end
      end
      sle_pkg::OP_MEMBER: begin
        out_d.found = found_any;
      end
      default: begin
        out_d.status = sle_pkg::STATUS_OK;
      end
    endcase
    out_d.entry_count = sle_pkg::CountBits'(count_d);
    out_d.is_empty    = count_d == '0;
    // Head after the operation reads zero on an empty list.
    head_wide         = (count_d == '0) ? 64'd0 : 64'(entries_d[0]);
    out_d.head_value  = head_wide[sle_pkg::KeyBits-1:0];
  end

  // Control state: fill count and order register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      signed_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        count_q <= count_d;
      end
      if (cfg_valid_i) begin
        signed_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_i.operation;
      key_q <= key_wide[KEY_WIDTH-1:0];
      pos_q <= in_i.position;
    end
    if (cmd_i.compare) begin
      gt_q <= gt_d;
      eq_q <= eq_d;
      rd_q <= rd_d;
    end
    if (cmd_i.commit) begin
      entries_q <= entries_d;
      out_q     <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

FILE: design/sorted_list_engine.sv
// Top level of the sorted list engine: controller, datapath and checks.
//
//   channel  direction  signals                               payload
//   in       in         in_valid_i / in_ready_o               sle_pkg::in_item_t
//   out      out        out_valid_o / out_ready_i             sle_pkg::out_item_t
//   cfg      in         cfg_valid_i / cfg_ready_o             cfg_data_i (compare_signed)
//
// An item passes through load, compare and commit from an idle start; a back to back item
// is loaded as the last one commits, after the registered compare stage ahead of the shift.
// A commit waits while the output register still holds an untaken result.
// Reset empties the list and selects unsigned order; no clearing pass is needed.
// The configuration port is always ready.
module sorted_list_engine #(
  parameter int unsigned CAPACITY  = sle_pkg::CapacityDef,
  parameter int unsigned KEY_WIDTH = sle_pkg::KeyWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sle_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sle_pkg::out_item_t out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);

  sle_pkg::dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  sle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Key cells and result register.
  sle_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_o       (out_o)
  );

  // An accepted item keeps the input side closed in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous item still in compare");

  // A full report only comes from a list at capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == sle_pkg::STATUS_FULL
      |-> out_o.entry_count == sle_pkg::CountBits'(CAPACITY))
    else $error("full status with list below capacity");

  // An empty list reports a zero head.
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.is_empty |-> out_o.head_value == '0)
    else $error("nonzero head on empty list");

  // A positive membership answer always carries the ok status.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.found |-> out_o.status == sle_pkg::STATUS_OK)
    else $error("found flag with error status");

endmodule
